[rtl/lpd_pkg.sv]
// Package: shared types and constants of the length-prefix deframer.
`default_nettype none
package lpd_pkg;

    // Stored length word: one 32-bit little-endian word
    localparam int LEN_BYTES = 4;
    localparam int LEN_W     = 8 * LEN_BYTES;
    localparam int BYTE_W    = 8;

    // Configuration port geometry
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = PADDR_W - 2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_HEADER_MODE = 1'b0;

    // One input word after the input register
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              buffer_end;
    } lpd_item_t;

    // One result word
    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              has_data;
        logic              first_of_packet;
        logic              last_of_packet;
        logic              bad_length;
        logic [LEN_W-1:0]  payload_length;
    } lpd_result_t;

    // Configuration toward the datapath
    typedef struct packed {
        logic header_mode;
        logic clear;
    } lpd_cfg_t;

endpackage
`default_nettype wire

[rtl/lpd_in_if.sv]
// Interface: input byte channel with valid/ready handshake.
`default_nettype none
interface lpd_in_if;
    logic                           valid;
    logic                           ready;
    logic [lpd_pkg::BYTE_W-1:0]     data_byte;
    logic                           buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface
`default_nettype wire

[rtl/lpd_out_if.sv]
// Interface: result channel with valid/ready handshake.
`default_nettype none
interface lpd_out_if;
    logic                           valid;
    logic                           ready;
    logic [lpd_pkg::BYTE_W-1:0]     payload_byte;
    logic                           has_data;
    logic                           first_of_packet;
    logic                           last_of_packet;
    logic                           bad_length;
    logic [lpd_pkg::LEN_W-1:0]      payload_length;

    modport source (output valid, output payload_byte, output has_data,
                    output first_of_packet, output last_of_packet,
                    output bad_length, output payload_length, input ready);
    modport sink   (input valid, input payload_byte, input has_data,
                    input first_of_packet, input last_of_packet,
                    input bad_length, input payload_length, output ready);
endinterface
`default_nettype wire

[rtl/lpd_apb_regs.sv]
// Module: APB configuration register block of the deframer.
`default_nettype none
module lpd_apb_regs
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lpd_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [lpd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [lpd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    output lpd_pkg::lpd_cfg_t                      cfg
);

    logic                               header_mode_reg;
    logic                               wr_mode;
    logic [lpd_pkg::REG_IDX_W-1:0]      reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[lpd_pkg::PADDR_W-1:2];
    assign wr_mode = psel && penable && pwrite && pready
                     && (reg_idx == lpd_pkg::REG_HEADER_MODE);

    // Hold the mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_mode_reg <= 1'b1;
        end
        else if (wr_mode)
        begin
            header_mode_reg <= pwdata[0];
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (reg_idx == lpd_pkg::REG_HEADER_MODE)
        begin
            prdata[0] = header_mode_reg;
        end
    end

    assign cfg.header_mode = header_mode_reg;
    assign cfg.clear       = wr_mode;

endmodule
`default_nettype wire

[rtl/lpd_in_stage.sv]
// Module: input register stage of the deframer.
`default_nettype none
module lpd_in_stage
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    lpd_in_if.sink              in_chan,
    input  wire logic           advance,
    output logic                item_valid,
    output lpd_pkg::lpd_item_t  item
);

    logic                 valid_reg;
    lpd_pkg::lpd_item_t   item_reg;
    logic                 take;

    // Accept when empty or when the held word moves on this cycle
    assign in_chan.ready = !valid_reg || advance;
    assign take          = in_chan.valid && in_chan.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Capture payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.data_byte  <= in_chan.data_byte;
            item_reg.buffer_end <= in_chan.buffer_end;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

[rtl/lpd_core.sv]
// Module: framing state, result logic and result register of the deframer.
`default_nettype none
module lpd_core
#(
    parameter int HEADER_BYTES = 4
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lpd_pkg::lpd_cfg_t   cfg,
    input  wire logic                item_valid,
    input  wire lpd_pkg::lpd_item_t  item,
    output logic                     advance,
    lpd_out_if.source                out_chan
);

    localparam logic [lpd_pkg::LEN_W-1:0] HDR_LEN = lpd_pkg::LEN_W'(HEADER_BYTES);
    localparam logic [3:0]                HDR_CNT = 4'(HEADER_BYTES);

    // Framing state
    logic [2:0]                 header_index_reg,  header_index_next;
    logic [lpd_pkg::LEN_W-1:0]  header_word_reg,   header_word_next;
    logic [lpd_pkg::LEN_W-1:0]  bytes_rem_reg,     bytes_rem_next;
    logic                       in_payload_reg,    in_payload_next;
    logic                       pt_started_reg,    pt_started_next;

    // Result register
    logic                       res_valid_reg;
    lpd_pkg::lpd_result_t       res_reg;
    lpd_pkg::lpd_result_t       res_next;
    logic                       produce;

    logic [lpd_pkg::LEN_W-1:0]  word_acc;
    logic [lpd_pkg::LEN_W-1:0]  total;

    // Move the held word when the result slot is free or drains now
    assign advance = item_valid && (!res_valid_reg || out_chan.ready);

    // Decode one byte against the framing state
    always_comb
    begin
        header_index_next = header_index_reg;
        header_word_next  = header_word_reg;
        bytes_rem_next    = bytes_rem_reg;
        in_payload_next   = in_payload_reg;
        pt_started_next   = pt_started_reg;
        res_next          = '0;
        produce           = 1'b0;
        total             = header_word_reg - HDR_LEN;

        // Merge the byte into its lane of the length word
        word_acc = header_word_reg;
        for (int k = 0; k < lpd_pkg::LEN_BYTES; k++)
        begin
            if (header_index_reg == 3'(k))
            begin
                word_acc[8*k +: 8] = word_acc[8*k +: 8] | item.data_byte;
            end
        end

        if (!cfg.header_mode)
        begin
            // Passthrough: every byte out, buffer end closes the packet
            produce                  = 1'b1;
            res_next.payload_byte    = item.data_byte;
            res_next.has_data        = 1'b1;
            res_next.first_of_packet = !pt_started_reg;
            res_next.last_of_packet  = item.buffer_end;
            pt_started_next          = !item.buffer_end;
        end
        else if (in_payload_reg)
        begin
            produce                  = 1'b1;
            res_next.payload_byte    = item.data_byte;
            res_next.has_data        = 1'b1;
            res_next.first_of_packet = (bytes_rem_reg == total);
            res_next.last_of_packet  = (bytes_rem_reg <= lpd_pkg::LEN_W'(1));
            res_next.payload_length  = total;
            bytes_rem_next           = bytes_rem_reg - lpd_pkg::LEN_W'(1);
            if (res_next.last_of_packet)
            begin
                bytes_rem_next    = '0;
                in_payload_next   = 1'b0;
                header_index_next = '0;
                header_word_next  = '0;
            end
        end
        else if (({1'b0, header_index_reg} + 4'd1) < HDR_CNT)
        begin
            // More header bytes to come
            header_index_next = header_index_reg + 3'd1;
            header_word_next  = word_acc;
        end
        else
        begin
            header_index_next = '0;
            if (word_acc < HDR_LEN)
            begin
                // Length too short: flag and hunt for a new header
                produce             = 1'b1;
                res_next.bad_length = 1'b1;
                header_word_next    = '0;
            end
            else if (word_acc == HDR_LEN)
            begin
                // Empty payload: single marker word
                produce                  = 1'b1;
                res_next.first_of_packet = 1'b1;
                res_next.last_of_packet  = 1'b1;
                header_word_next         = '0;
            end
            else
            begin
                header_word_next = word_acc;
                bytes_rem_next   = word_acc - HDR_LEN;
                in_payload_next  = 1'b1;
            end
        end
    end

    // Advance framing state; a mode write drops the framing state in progress
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_index_reg <= '0;
            header_word_reg  <= '0;
            bytes_rem_reg    <= '0;
            in_payload_reg   <= 1'b0;
            pt_started_reg   <= 1'b0;
        end
        else if (cfg.clear)
        begin
            header_index_reg <= '0;
            header_word_reg  <= '0;
            bytes_rem_reg    <= '0;
            in_payload_reg   <= 1'b0;
            pt_started_reg   <= 1'b0;
        end
        else if (advance)
        begin
            header_index_reg <= header_index_next;
            header_word_reg  <= header_word_next;
            bytes_rem_reg    <= bytes_rem_next;
            in_payload_reg   <= in_payload_next;
            pt_started_reg   <= pt_started_next;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= produce;
        end
        else if (out_chan.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            res_reg <= res_next;
        end
    end

    assign out_chan.valid           = res_valid_reg;
    assign out_chan.payload_byte    = res_reg.payload_byte;
    assign out_chan.has_data        = res_reg.has_data;
    assign out_chan.first_of_packet = res_reg.first_of_packet;
    assign out_chan.last_of_packet  = res_reg.last_of_packet;
    assign out_chan.bad_length      = res_reg.bad_length;
    assign out_chan.payload_length  = res_reg.payload_length;

`ifndef SYNTH
    // Error word carries no byte and no packet marks
    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.bad_length) |->
        (!res_reg.has_data && !res_reg.first_of_packet && !res_reg.last_of_packet))
        else $error("error word carries data or marks");

    // No payload count outside a payload
    a_rem_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_payload_reg |-> (bytes_rem_reg == '0))
        else $error("bytes remaining outside a payload");

    // Header assembly is idle while passing payload
    a_hdr_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (header_index_reg == '0 && bytes_rem_reg != '0))
        else $error("header index moved during payload");

    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !out_chan.ready) |=> (res_valid_reg && $stable(res_reg)))
        else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

[rtl/length_prefix_deframer_unit.sv]
// Top level: length-prefix deframer with APB configuration.
// Bytes pass the input register, then the result register; a header gives
// a result only if too short or empty. Throughput: one byte per cycle when
// not stalled; result stalls back up through the input register only.
// Reset: all framing state cleared, header_mode set to 1 (length headers).
// A write of header_mode also clears the framing state.
`default_nettype none
module length_prefix_deframer_unit
#(
    parameter int HEADER_BYTES = 4
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lpd_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [lpd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [lpd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    lpd_in_if.sink                                 in_chan,
    lpd_out_if.source                              out_chan
);

    lpd_pkg::lpd_cfg_t   cfg;
    lpd_pkg::lpd_item_t  item;
    logic                item_valid;
    logic                advance;

    lpd_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lpd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_chan    (in_chan),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    lpd_core
    #(
        .HEADER_BYTES (HEADER_BYTES)
    )
    u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .out_chan   (out_chan)
    );

endmodule
`default_nettype wire

[tb/tb_length_prefix_deframer_unit.sv]
`timescale 1ns / 100ps
// Testbench: self-checking regression of the length-prefix deframer unit.
module tb_length_prefix_deframer_unit;

    localparam int HDR_BYTES     = 4;
    localparam int SETTLE_CYCLES = 6;
    localparam int NUM_PHASES    = 9;
    localparam int PHASE_BYTES   = 185;
    localparam int MAX_PRINTS    = 40;

    // Index one past the register list: writes there must be ignored
    localparam logic [lpd_pkg::REG_IDX_W-1:0] REG_UNMAPPED =
        lpd_pkg::REG_HEADER_MODE + 1'b1;

    typedef enum logic {ROW_BYTE, ROW_MODE} row_op_t;

    typedef struct {
        row_op_t              op;
        logic [7:0]           data;
        logic                 bend;
        logic                 fixed;
        lpd_pkg::lpd_result_t res;
    } stim_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [lpd_pkg::PADDR_W-1:0]    paddr;
    logic [lpd_pkg::APB_DATA_W-1:0] pwdata;
    logic [lpd_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    lpd_in_if  in_chan ();
    lpd_out_if out_chan ();

    length_prefix_deframer_unit #(.HEADER_BYTES(HDR_BYTES)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

    // Deframer state mirrored by the predictor
    logic        mode_hdr;
    logic [2:0]  hdr_count;
    logic [31:0] len_word;
    logic [31:0] body_left;
    logic        in_body;
    logic        pt_open;

    lpd_pkg::lpd_result_t pending_results[$];
    stim_row_t            directed_rows[$];

    int burst_left     = 0;
    int bytes_sent     = 0;
    int results_seen   = 0;
    int packets_closed = 0;
    int length_errors  = 0;
    int mode_writes    = 0;
    int mismatch_count = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic lpd_pkg::lpd_result_t pack_result(
        input logic [7:0] b, input logic has,
        input logic first_mark, input logic last_mark,
        input logic bad, input logic [31:0] plen);
        lpd_pkg::lpd_result_t r;
        r.payload_byte    = b;
        r.has_data        = has;
        r.first_of_packet = first_mark;
        r.last_of_packet  = last_mark;
        r.bad_length      = bad;
        r.payload_length  = plen;
        return r;
    endfunction

    function automatic logic one_in(input int n);
        return $urandom_range(0, n - 1) == 0;
    endfunction

    function automatic logic [lpd_pkg::PADDR_W-1:0] reg_addr(
        input logic [lpd_pkg::REG_IDX_W-1:0] idx);
        return {idx, 2'b00};
    endfunction

    function automatic void clear_framing();
        hdr_count = '0;
        len_word  = '0;
        body_left = '0;
        in_body   = 1'b0;
        pt_open   = 1'b0;
    endfunction

    // Advance the mirrored state by one byte and return the result it causes, if any
    function automatic void deframe_byte(input logic [7:0] d, input logic be,
                                         output logic produced,
                                         output lpd_pkg::lpd_result_t r);
        logic [31:0] total;
        logic        is_last;
        produced = 1'b0;
        r        = '0;
        if (!mode_hdr)
        begin
            // Passthrough: every byte goes out, buffer end closes the packet
            r        = pack_result(d, 1'b1, !pt_open, be, 1'b0, 32'd0);
            produced = 1'b1;
            pt_open  = !be;
        end
        else if (in_body)
        begin
            total     = len_word - HDR_BYTES;
            is_last   = body_left <= 32'd1;
            r         = pack_result(d, 1'b1, body_left == total, is_last, 1'b0, total);
            produced  = 1'b1;
            body_left = body_left - 32'd1;
            if (is_last)
                clear_framing();
        end
        else
        begin
            // Header byte: only the first four land in the length word
            if (hdr_count < lpd_pkg::LEN_BYTES)
                len_word = len_word | (32'(d) << (8 * hdr_count));
            if (hdr_count + 1 < HDR_BYTES)
                hdr_count = hdr_count + 3'd1;
            else
            begin
                hdr_count = '0;
                if (len_word < HDR_BYTES)
                begin
                    r        = pack_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 32'd0);
                    produced = 1'b1;
                    len_word = '0;
                end
                else if (len_word == HDR_BYTES)
                begin
                    r        = pack_result(8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 32'd0);
                    produced = 1'b1;
                    len_word = '0;
                end
                else
                begin
                    body_left = len_word - HDR_BYTES;
                    in_body   = 1'b1;
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("ERROR %0t ns: %s got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // One APB transfer: setup phase, access until pready, then back to idle
    task automatic apb_access(input logic wr, input logic [lpd_pkg::PADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata    = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Hold the sender until every pending result is in, then let the pipe settle
    task automatic drain_results();
        in_chan.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_mode(input logic m);
        logic [31:0] rdata;
        drain_results();
        apb_access(1'b1, reg_addr(lpd_pkg::REG_HEADER_MODE), {31'd0, m}, rdata);
        mode_hdr = m;
        clear_framing();
        mode_writes++;
        apb_access(1'b0, reg_addr(lpd_pkg::REG_HEADER_MODE), 32'd0, rdata);
        if (rdata !== {31'd0, m})
            report_mismatch("header_mode readback", rdata, {31'd0, m});
    endtask

    // Offer one word in bursts; predict once it is taken
    task automatic send_byte(input logic [7:0] d, input logic be, input logic fixed,
                             input lpd_pkg::lpd_result_t fixed_res);
        lpd_pkg::lpd_result_t predicted;
        logic                 produced;
        int                   gap;
        if (burst_left == 0)
        begin
            gap = one_in(4) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                in_chan.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        in_chan.valid      <= 1'b1;
        in_chan.data_byte  <= d;
        in_chan.buffer_end <= be;
        do
            @(posedge clk);
        while (!in_chan.ready);
        bytes_sent++;
        deframe_byte(d, be, produced, predicted);
        if (fixed)
            pending_results.push_back(fixed_res);
        else if (produced)
            pending_results.push_back(predicted);
    endtask

    function automatic stim_row_t byte_row(input logic [7:0] d, input logic be);
        stim_row_t r;
        r.op    = ROW_BYTE;
        r.data  = d;
        r.bend  = be;
        r.fixed = 1'b0;
        r.res   = '0;
        return r;
    endfunction

    function automatic stim_row_t fixed_row(input logic [7:0] d, input logic be,
                                            input lpd_pkg::lpd_result_t res);
        stim_row_t r;
        r       = byte_row(d, be);
        r.fixed = 1'b1;
        r.res   = res;
        return r;
    endfunction

    function automatic stim_row_t mode_row(input logic m);
        stim_row_t r;
        r    = byte_row({7'd0, m}, 1'b0);
        r.op = ROW_MODE;
        return r;
    endfunction

    // Receiver: ready follows a rotating pattern that is reloaded with a random one
    initial
    begin
        logic [31:0] stall_bits;
        int          stall_tick;
        stall_bits      = '1;
        stall_tick      = 0;
        out_chan.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            stall_tick++;
            if (stall_tick % 64 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_bits = '1;
                    1:       stall_bits = $urandom;
                    2:       stall_bits = $urandom | $urandom;
                    default: stall_bits = $urandom & $urandom;
                endcase
            end
            out_chan.ready <= stall_bits[0];
            stall_bits      = {stall_bits[0], stall_bits[31:1]};
        end
    end

    // Compare each accepted result with the oldest pending one
    always @(posedge clk)
    begin
        lpd_pkg::lpd_result_t want;
        if (rst_n && out_chan.valid && out_chan.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("result with none pending", 32'd1, 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (out_chan.payload_byte !== want.payload_byte)
                    report_mismatch("payload_byte", out_chan.payload_byte, want.payload_byte);
                if (out_chan.has_data !== want.has_data)
                    report_mismatch("has_data", out_chan.has_data, want.has_data);
                if (out_chan.first_of_packet !== want.first_of_packet)
                    report_mismatch("first_of_packet", out_chan.first_of_packet,
                                    want.first_of_packet);
                if (out_chan.last_of_packet !== want.last_of_packet)
                    report_mismatch("last_of_packet", out_chan.last_of_packet,
                                    want.last_of_packet);
                if (out_chan.bad_length !== want.bad_length)
                    report_mismatch("bad_length", out_chan.bad_length, want.bad_length);
                if (out_chan.payload_length !== want.payload_length)
                    report_mismatch("payload_length", out_chan.payload_length,
                                    want.payload_length);
                if (want.last_of_packet)
                    packets_closed++;
                if (want.bad_length)
                    length_errors++;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic [31:0]          rdata;
        logic [31:0]          len;
        int                   plen;
        int                   pick;
        int                   n;
        int                   phase_start;
        lpd_pkg::lpd_result_t bad_len_res;
        lpd_pkg::lpd_result_t empty_res;
        stim_row_t            row;

        bad_len_res = pack_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 32'd0);
        empty_res   = pack_result(8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 32'd0);

        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_chan.valid      <= 1'b0;
        in_chan.data_byte  <= '0;
        in_chan.buffer_end <= 1'b0;
        mode_hdr            = 1'b1;
        clear_framing();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register must come up in header mode
        apb_access(1'b0, reg_addr(lpd_pkg::REG_HEADER_MODE), 32'd0, rdata);
        if (rdata !== 32'd1)
            report_mismatch("header_mode after reset", rdata, 32'd1);

        // Zero length and length just under the header: error results
        directed_rows.push_back(byte_row(8'h00, 1'b0));
        directed_rows.push_back(byte_row(8'h00, 1'b0));
        directed_rows.push_back(byte_row(8'h00, 1'b0));
        directed_rows.push_back(fixed_row(8'h00, 1'b0, bad_len_res));
        directed_rows.push_back(byte_row(8'h03, 1'b0));
        directed_rows.push_back(byte_row(8'h00, 1'b0));
        directed_rows.push_back(byte_row(8'h00, 1'b0));
        directed_rows.push_back(fixed_row(8'h00, 1'b0, bad_len_res));
        // Empty payload: one marker
        directed_rows.push_back(byte_row(8'h04, 1'b0));
        directed_rows.push_back(byte_row(8'h00, 1'b0));
        directed_rows.push_back(byte_row(8'h00, 1'b0));
        directed_rows.push_back(fixed_row(8'h00, 1'b0, empty_res));
        // One-byte payload; buffer end inside the header is ignored
        directed_rows.push_back(byte_row(8'h05, 1'b0));
        directed_rows.push_back(byte_row(8'h00, 1'b1));
        directed_rows.push_back(byte_row(8'h00, 1'b0));
        directed_rows.push_back(byte_row(8'h00, 1'b0));
        directed_rows.push_back(fixed_row(8'hFF, 1'b0,
                                          pack_result(8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 32'd1)));
        // Largest length: start the payload, then drop it with a mode write
        directed_rows.push_back(byte_row(8'hFF, 1'b0));
        directed_rows.push_back(byte_row(8'hFF, 1'b0));
        directed_rows.push_back(byte_row(8'hFF, 1'b0));
        directed_rows.push_back(byte_row(8'hFF, 1'b0));
        directed_rows.push_back(fixed_row(8'h80, 1'b1,
                                          pack_result(8'h80, 1'b1, 1'b1, 1'b0, 1'b0,
                                                      32'hFFFF_FFFB)));
        directed_rows.push_back(fixed_row(8'h7F, 1'b0,
                                          pack_result(8'h7F, 1'b1, 1'b0, 1'b0, 1'b0,
                                                      32'hFFFF_FFFB)));
        // Passthrough: open, close, and a one-byte buffer
        directed_rows.push_back(mode_row(1'b0));
        directed_rows.push_back(fixed_row(8'hA5, 1'b0,
                                          pack_result(8'hA5, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0)));
        directed_rows.push_back(fixed_row(8'h5A, 1'b1,
                                          pack_result(8'h5A, 1'b1, 1'b0, 1'b1, 1'b0, 32'd0)));
        directed_rows.push_back(fixed_row(8'h00, 1'b1,
                                          pack_result(8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0)));
        directed_rows.push_back(mode_row(1'b1));

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.op == ROW_MODE)
                write_mode(row.data[0]);
            else
                send_byte(row.data, row.bend, row.fixed, row.res);
        end

        // Random phases: header mode mostly well-formed packets, passthrough random buffers
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 6)
            begin
                // Write past the register list; framing state must carry over
                drain_results();
                apb_access(1'b1, reg_addr(REG_UNMAPPED), 32'd0, rdata);
            end
            else
                write_mode(p % 3 != 1);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                if (!mode_hdr)
                    send_byte(8'($urandom), one_in(8), 1'b0, '0);
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70)
                    begin
                        plen = one_in(10) ? $urandom_range(17, 64) : $urandom_range(1, 16);
                        len  = plen + HDR_BYTES;
                    end
                    else if (pick < 82)
                    begin
                        plen = 0;
                        len  = HDR_BYTES;
                    end
                    else
                    begin
                        plen = 0;
                        len  = $urandom_range(0, HDR_BYTES - 1);
                    end
                    for (int k = 0; k < lpd_pkg::LEN_BYTES; k++)
                        send_byte(len[8*k +: 8], one_in(8), 1'b0, '0);
                    for (int k = 0; k < plen; k++)
                        send_byte(8'($urandom), one_in(8), 1'b0, '0);
                end
            end
            // Broken tail: partial header, or a random header with a few bytes after it
            if (mode_hdr && one_in(2))
            begin
                n = one_in(2) ? $urandom_range(1, HDR_BYTES - 1)
                              : HDR_BYTES + $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                    send_byte(8'($urandom), one_in(8), 1'b0, '0);
            end
        end

        drain_results();
        $display("Covered %0d bytes and %0d results over %0d mode writes.",
                 bytes_sent, results_seen, mode_writes);
        $display("Closed %0d packets, saw %0d bad-length headers, %0d mismatches.",
                 packets_closed, length_errors, mismatch_count);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
